[hw/rtl/greedy_note_dispenser_top_macros.svh]
// ----------------------------------------------------------------------------
// Greedy note dispenser assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_NOTE_DISPENSER_TOP_MACROS_SVH
`define GREEDY_NOTE_DISPENSER_TOP_MACROS_SVH

// Checks a property at every rising edge of clk outside reset.
`define GND_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds.
`define GND_ASSERT_NEVER(lbl, cond, msg) \
	`GND_ASSERT(lbl, !(cond), msg)

`endif

[hw/rtl/gnd_pkg.sv]
// ----------------------------------------------------------------------------
// Greedy note dispenser package
// Sequencer states, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package gnd_pkg;

	localparam int VAL_W  = 16;
	localparam int STAT_W = 2;

	typedef logic [STAT_W-1:0] status_t;

	localparam status_t STAT_OK      = 2'd0;
	localparam status_t STAT_INEXACT = 2'd1;
	localparam status_t STAT_FULL    = 2'd2;
	localparam status_t STAT_SAT     = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_ADD_WR,
		ST_WD_SCAN,
		ST_WD_DIV,
		ST_WD_MUL,
		ST_WD_SUB,
		ST_PAY,
		ST_RESP
	} state_t;

endpackage

[hw/rtl/greedy_note_dispenser_top.sv]
// ----------------------------------------------------------------------------
// Greedy note dispenser
// Stock table of note values and counts with a greedy, exact withdrawal.
// ----------------------------------------------------------------------------
// The s_ channel takes one beat per request: tuser is the action (0 add,
// 1 withdraw) and tdata packs note_value, note_count and amount. The m_
// channel gives the results: tuser is the status, tdata packs paid_value
// and paid_count, and tlast marks the final beat of a request.
// An add scans the table one slot per cycle and then writes its slot. A
// withdrawal runs rounds of a slot scan, a restoring divide, a multiply
// and a subtract. After at most SLOTS rounds it either pays out one beat
// per cycle while the receiver takes them, or ends with a scan that finds
// nothing and a failure beat. Requests of zero notes or a zero amount go
// straight to their response.
// s_tready is high only while the sequencer is idle; it does not wait for
// the last result to be taken. Results are held in an output register, and
// a stalled receiver holds the sequencer at its next result.
// Reset empties the stock table at once and drops m_tvalid.
// ----------------------------------------------------------------------------
`include "greedy_note_dispenser_top_macros.svh"

module greedy_note_dispenser_top
	import gnd_pkg::*;
#(
	parameter int SLOTS      = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // note_value, note_count, amount
	input  logic        s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // paid_value, paid_count
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CW    = (COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W;
	localparam int SUM_W = CW + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

	state_t state_q, state_d;

	logic [VAL_W-1:0]      val_arr_q [SLOTS];
	logic [COUNT_BITS-1:0] cnt_arr_q [SLOTS];
	logic [SLOTS-1:0]      in_use_q;
	logic [SLOTS-1:0]      seen_q;

	logic [VAL_W-1:0]      note_val_q;
	logic [VAL_W-1:0]      note_cnt_q;
	logic [VAL_W-1:0]      remain_q;
	logic [IDX_W-1:0]      scan_idx_q;
	logic                  match_found_q;
	logic [IDX_W-1:0]      match_idx_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  best_found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [VAL_W-1:0]      best_val_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [VAL_W-1:0]      div_r_q;
	logic [VAL_W-1:0]      div_n_q;
	logic [3:0]            div_cnt_q;
	logic [2*VAL_W-1:0]    prod_q;
	logic [IDX_W-1:0]      order_q [SLOTS];
	logic [VAL_W-1:0]      take_q [SLOTS];
	logic [CNT_W-1:0]      used_q;
	logic [IDX_W-1:0]      pay_idx_q;
	status_t               resp_status_q;

	logic                  m_tvalid_q;
	logic [VAL_W-1:0]      paid_val_q;
	logic [VAL_W-1:0]      paid_cnt_q;
	status_t               m_status_q;
	logic                  m_last_q;

	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	logic                  scan_end;
	logic [IDX_W-1:0]      add_slot;
	logic [IDX_W-1:0]      pay_slot;
	logic [IDX_W-1:0]      rd_idx;
	logic [VAL_W-1:0]      rd_val;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic                  rd_use;
	logic                  cand;
	logic                  best_found_nx;
	logic [COUNT_BITS-1:0] add_base;
	logic [SUM_W-1:0]      add_sum;
	logic                  add_sat;
	logic [VAL_W:0]        div_rem_w;
	logic                  div_ge;
	logic [VAL_W-1:0]      take_k;
	logic [VAL_W-1:0]      remain_nx;
	logic                  pay_last;
	logic [VAL_W-1:0]      pay_take;
	logic [COUNT_BITS-1:0] pay_cnt_nx;

	// Control outputs of the sequencer.
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		out_free = !m_tvalid_q || m_tready;
		out_load = ((state_q == ST_PAY) || (state_q == ST_RESP)) && out_free;
	end

	assign accept   = s_tvalid && s_tready;
	assign scan_end = (scan_idx_q == LAST_IDX);
	assign add_slot = match_found_q ? match_idx_q : free_idx_q;
	assign pay_slot = order_q[pay_idx_q];
	assign pay_take = take_q[pay_idx_q];
	assign pay_last = (CNT_W'(pay_idx_q) == (used_q - CNT_W'(1)));

	always_comb begin
		unique case (state_q)
			ST_ADD_WR: rd_idx = add_slot;
			ST_PAY:    rd_idx = pay_slot;
			default:   rd_idx = scan_idx_q;
		endcase
	end

	assign rd_val = val_arr_q[rd_idx];
	assign rd_cnt = cnt_arr_q[rd_idx];
	assign rd_use = in_use_q[rd_idx];

	assign cand = !seen_q[scan_idx_q] && rd_use && (rd_cnt != '0) && (rd_val != '0)
		&& (rd_val <= remain_q) && (!best_found_q || (rd_val > best_val_q));
	assign best_found_nx = best_found_q || cand;

	assign add_base = match_found_q ? rd_cnt : '0;
	assign add_sum  = SUM_W'(add_base) + SUM_W'(note_cnt_q);
	assign add_sat  = (add_sum > SUM_W'(CMAX));

	assign div_rem_w = {div_r_q, div_n_q[VAL_W-1]};
	assign div_ge    = (div_rem_w >= {1'b0, best_val_q});

	assign take_k    = (CW'(div_n_q) > CW'(best_cnt_q)) ? VAL_W'(best_cnt_q) : div_n_q;
	assign remain_nx = remain_q - prod_q[VAL_W-1:0];
	assign pay_cnt_nx = rd_cnt - COUNT_BITS'(pay_take);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!s_tuser) begin
						state_d = (s_tdata[31:16] == '0) ? ST_RESP : ST_ADD_SCAN;
					end else begin
						state_d = (s_tdata[47:32] == '0) ? ST_RESP : ST_WD_SCAN;
					end
				end
			end
			ST_ADD_SCAN: begin
				if (scan_end) begin
					state_d = ST_ADD_WR;
				end
			end
			ST_ADD_WR: state_d = ST_RESP;
			ST_WD_SCAN: begin
				if (scan_end) begin
					state_d = best_found_nx ? ST_WD_DIV : ST_RESP;
				end
			end
			ST_WD_DIV: begin
				if (div_cnt_q == 4'd15) begin
					state_d = ST_WD_MUL;
				end
			end
			ST_WD_MUL: state_d = ST_WD_SUB;
			ST_WD_SUB: state_d = (remain_nx == '0) ? ST_PAY : ST_WD_SCAN;
			ST_PAY: begin
				if (out_free && pay_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Slot occupancy and round bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q     <= '0;
			seen_q       <= '0;
			used_q       <= '0;
			best_found_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					seen_q       <= '0;
					used_q       <= '0;
					best_found_q <= 1'b0;
				end
				ST_ADD_WR: begin
					if (match_found_q || free_found_q) begin
						in_use_q[add_slot] <= 1'b1;
					end
				end
				ST_WD_SCAN: begin
					best_found_q <= best_found_nx;
				end
				ST_WD_MUL: begin
					seen_q[best_idx_q] <= 1'b1;
					used_q             <= used_q + CNT_W'(1);
				end
				ST_WD_SUB: begin
					best_found_q <= 1'b0;
				end
				ST_PAY: begin
					if (out_free && (pay_cnt_nx == '0)) begin
						in_use_q[pay_slot] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Stock storage.
	always_ff @(posedge clk) begin
		if ((state_q == ST_ADD_WR) && (match_found_q || free_found_q)) begin
			val_arr_q[add_slot] <= note_val_q;
			cnt_arr_q[add_slot] <= add_sat ? CMAX : add_sum[COUNT_BITS-1:0];
		end else if ((state_q == ST_PAY) && out_free) begin
			cnt_arr_q[pay_slot] <= pay_cnt_nx;
			if (pay_cnt_nx == '0) begin
				val_arr_q[pay_slot] <= '0;
			end
		end
	end

	// Working registers of the shared scan, divide and multiply unit.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				note_val_q    <= s_tdata[15:0];
				note_cnt_q    <= s_tdata[31:16];
				remain_q      <= s_tdata[47:32];
				scan_idx_q    <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				pay_idx_q     <= '0;
				resp_status_q <= STAT_OK;
			end
			ST_ADD_SCAN: begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (!match_found_q && rd_use && (rd_val == note_val_q)) begin
					match_found_q <= 1'b1;
					match_idx_q   <= scan_idx_q;
				end
				if (!free_found_q && !rd_use) begin
					free_found_q <= 1'b1;
					free_idx_q   <= scan_idx_q;
				end
			end
			ST_ADD_WR: begin
				if (!match_found_q && !free_found_q) begin
					resp_status_q <= STAT_FULL;
				end else if (add_sat) begin
					resp_status_q <= STAT_SAT;
				end else begin
					resp_status_q <= STAT_OK;
				end
			end
			ST_WD_SCAN: begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (cand) begin
					best_idx_q <= scan_idx_q;
					best_val_q <= rd_val;
					best_cnt_q <= rd_cnt;
				end
				if (scan_end) begin
					div_r_q   <= '0;
					div_n_q   <= remain_q;
					div_cnt_q <= '0;
					if (!best_found_nx) begin
						resp_status_q <= STAT_INEXACT;
					end
				end
			end
			ST_WD_DIV: begin
				div_r_q   <= div_ge ? VAL_W'(div_rem_w - {1'b0, best_val_q})
					: div_rem_w[VAL_W-1:0];
				div_n_q   <= {div_n_q[VAL_W-2:0], div_ge};
				div_cnt_q <= div_cnt_q + 4'd1;
			end
			ST_WD_MUL: begin
				prod_q                      <= take_k * best_val_q;
				take_q[used_q[IDX_W-1:0]]  <= take_k;
				order_q[used_q[IDX_W-1:0]] <= best_idx_q;
			end
			ST_WD_SUB: begin
				remain_q   <= remain_nx;
				scan_idx_q <= '0;
			end
			ST_PAY: begin
				if (out_free) begin
					pay_idx_q <= pay_idx_q + IDX_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_PAY) begin
				m_status_q <= STAT_OK;
				paid_val_q <= rd_val;
				paid_cnt_q <= pay_take;
				m_last_q   <= pay_last;
			end else begin
				m_status_q <= resp_status_q;
				paid_val_q <= '0;
				paid_cnt_q <= '0;
				m_last_q   <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {paid_cnt_q, paid_val_q};
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

	`GND_ASSERT(a_pay_in_range, (state_q == ST_PAY) |-> (CNT_W'(pay_idx_q) < used_q),
		"Payout index ran past the recorded denominations.")
	`GND_ASSERT(a_pay_slot_live, (state_q == ST_PAY) |-> in_use_q[pay_slot],
		"Payout reads a slot that is not in use.")
	`GND_ASSERT_NEVER(a_div_zero, (state_q == ST_WD_DIV) && (best_val_q == '0),
		"Divider started with a zero divisor.")
	`GND_ASSERT(a_round_count, (state_q == ST_WD_MUL) |=> (used_q == $past(used_q) + CNT_W'(1)),
		"Round count did not advance after a take.")

endmodule
